### src/dhd_pkg.sv
package dhd_pkg;

    // Fixed point format of all box values and scores.
    localparam int FRAC_BITS = 16;

    // Largest class count that the block honors.
    localparam int MAX_CLASSES = 256;

    // Channels 0 to 3 carry the box, class scores follow.
    localparam logic [8:0] BOX_CHANNELS = 9'd4;

    // Class code of an anchor that has no positive score yet.
    localparam logic [8:0] NO_CLASS = 9'h1FF;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CLASS_COUNT     = 3'd0;
    localparam logic [2:0] CFG_SCORE_THRESHOLD = 3'd1;
    localparam logic [2:0] CFG_PAD_LEFT        = 3'd2;
    localparam logic [2:0] CFG_PAD_TOP         = 3'd3;
    localparam logic [2:0] CFG_INVERSE_SCALE   = 3'd4;
    localparam logic [2:0] CFG_FRAME_WIDTH     = 3'd5;
    localparam logic [2:0] CFG_FRAME_HEIGHT    = 3'd6;

    // Configuration register file.
    typedef struct packed {
        logic [8:0]  class_count;
        logic [16:0] score_threshold;
        logic [28:0] pad_left;
        logic [28:0] pad_top;
        logic [23:0] inverse_scale;
        logic [13:0] frame_width;
        logic [13:0] frame_height;
    } t_cfg;

    // Running best score and class of one anchor.
    typedef struct packed {
        logic [8:0]         cls;
        logic signed [31:0] score;
    } t_best;

    // Anchor that passed the score checks, with its stored box.
    typedef struct packed {
        logic [13:0]        anchor;
        logic [7:0]         cls;
        logic [30:0]        score;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] w;
        logic signed [31:0] h;
    } t_cand;

endpackage

### src/dhd_if.sv
// Tensor element channel.
interface dhd_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] tensor_value;
    logic [8:0]         channel_index;
    logic [13:0]        anchor_index;

    modport source (output valid, output tensor_value, output channel_index,
                    output anchor_index, input ready);
    modport sink (input valid, input tensor_value, input channel_index,
                  input anchor_index, output ready);
endinterface

// Detection channel.
interface dhd_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] det_anchor;
    logic [7:0]  det_class;
    logic [30:0] det_score;
    logic [29:0] box_left;
    logic [29:0] box_top;
    logic [29:0] box_width;
    logic [29:0] box_height;

    modport source (output valid, output det_anchor, output det_class,
                    output det_score, output box_left, output box_top,
                    output box_width, output box_height, input ready);
    modport sink (input valid, input det_anchor, input det_class,
                  input det_score, input box_left, input box_top,
                  input box_width, input box_height, output ready);
endinterface

### src/dhd_ram.sv
module dhd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port; a read at the address
    // being written returns the old contents. Read data holds when idle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### src/dhd_anchor_state.sv
module dhd_anchor_state #(
    parameter int MAX_ANCHORS = 16384
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dhd_in_if.sink        i_in,
    input  dhd_pkg::t_cfg i_cfg,
    output logic          o_cand_valid,
    input  logic          i_cand_ready,
    output dhd_pkg::t_cand o_cand
);
    import dhd_pkg::*;

    localparam int AW = MAX_ANCHORS > 1 ? $clog2(MAX_ANCHORS) : 1;

    // Decode of the element offered on the input channel.
    logic [16:0]  a_wide;
    logic         a_ok;
    logic         is_box;
    logic [8:0]   count;
    logic [8:0]   k;
    logic         in_range;
    logic         accept;
    logic         best_re;
    logic         box_re;
    logic [3:0]   box_we;
    logic [AW-1:0] addr;

    // Read-modify-write stage.
    logic          r_v1;
    logic [AW-1:0] r_addr;
    logic [13:0]   r_anchor;
    logic signed [31:0] r_val;
    logic [8:0]    r_k;
    logic          r_first;
    logic          r_last;
    logic          s1_go;
    logic          keep;
    t_best         best_q;
    t_best         base;
    t_best         n_best;

    // Last write into the best store, forwarded to a read that missed it.
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    t_best         r_fwd_data;

    logic [31:0]   box_q [4];

    always_comb begin
        a_wide   = {3'b000, i_in.anchor_index};
        a_ok     = a_wide < 17'(MAX_ANCHORS);
        addr     = a_wide[AW-1:0];
        is_box   = i_in.channel_index < BOX_CHANNELS;
        count    = (i_cfg.class_count < 9'(MAX_CLASSES)) ? i_cfg.class_count
                                                         : 9'(MAX_CLASSES);
        k        = i_in.channel_index - BOX_CHANNELS;
        in_range = !is_box && (k < count);
    end

    // The stage takes a new element once its current one has left.
    assign i_in.ready = !r_v1 || s1_go;
    assign accept     = i_in.valid && i_in.ready;
    assign best_re    = accept && a_ok && in_range;
    assign box_re     = best_re && (k == count - 9'd1);

    always_comb begin
        box_we = '0;
        if (accept && a_ok && is_box) begin
            box_we[i_in.channel_index[1:0]] = 1'b1;
        end
    end

    // Box store: one bank per box channel, all read together on the last
    // class channel of an anchor.
    for (genvar b = 0; b < 4; b++) begin : g_box
        dhd_ram #(
            .WIDTH (32),
            .DEPTH (MAX_ANCHORS)
        ) u_box_ram (
            .i_clk   (i_clk),
            .i_we    (box_we[b]),
            .i_waddr (addr),
            .i_wdata (i_in.tensor_value),
            .i_re    (box_re),
            .i_raddr (addr),
            .o_rdata (box_q[b])
        );
    end

    // Best score and class store.
    dhd_ram #(
        .WIDTH ($bits(t_best)),
        .DEPTH (MAX_ANCHORS)
    ) u_best_ram (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_addr),
        .i_wdata (n_best),
        .i_re    (best_re),
        .i_raddr (addr),
        .o_rdata (best_q)
    );

    // Stage registers follow the read that was issued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_in.ready) begin
            r_v1 <= best_re;
        end
        if (best_re) begin
            r_addr   <= addr;
            r_anchor <= i_in.anchor_index;
            r_val    <= i_in.tensor_value;
            r_k      <= k;
            r_first  <= (k == 9'd0);
            r_last   <= (k == count - 9'd1);
        end
    end

    // Running best update, with the first class channel restarting it.
    always_comb begin
        if (r_first) begin
            base.cls   = NO_CLASS;
            base.score = 32'sd0;
        end else if (r_fwd_valid && (r_fwd_addr == r_addr)) begin
            base = r_fwd_data;
        end else begin
            base = best_q;
        end
        n_best = base;
        if (r_val > base.score) begin
            n_best.score = r_val;
            n_best.cls   = r_k;
        end
        keep = r_last && (n_best.cls != NO_CLASS) && (n_best.score > 32'sd0)
               && (n_best.score >= $signed({15'b0, i_cfg.score_threshold}));
    end

    // An element that yields no detection leaves at once; a kept one waits
    // for the box pipeline to take it.
    assign s1_go = r_v1 && (!keep || i_cand_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (s1_go) begin
            r_fwd_valid <= 1'b1;
        end
        if (s1_go) begin
            r_fwd_addr <= r_addr;
            r_fwd_data <= n_best;
        end
    end

    // Candidate handed to the box pipeline.
    always_comb begin
        o_cand_valid  = r_v1 && keep;
        o_cand.anchor = r_anchor;
        o_cand.cls    = n_best.cls[7:0];
        o_cand.score  = n_best.score[30:0];
        o_cand.cx     = $signed(box_q[0]);
        o_cand.cy     = $signed(box_q[1]);
        o_cand.w      = $signed(box_q[2]);
        o_cand.h      = $signed(box_q[3]);
    end

endmodule

### src/dhd_box_math.sv
module dhd_box_math (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dhd_pkg::t_cfg  i_cfg,
    input  logic           i_cand_valid,
    output logic           o_cand_ready,
    input  dhd_pkg::t_cand i_cand,
    dhd_out_if.source      o_out
);
    import dhd_pkg::*;

    localparam int DW = 35;
    localparam int PW = 60;
    localparam int SW = 57;
    localparam logic signed [SW-1:0] ONE = SW'(1) << FRAC_BITS;

    logic [29:0] fw;
    logic [29:0] fh;

    // Stage 2: candidate as taken.
    logic  r_v2;
    t_cand r_c2;
    // Stage 3: offsets from the pads.
    logic  r_v3;
    logic [13:0] r_anchor3;
    logic [7:0]  r_cls3;
    logic [30:0] r_score3;
    logic signed [DW-1:0] r_dx3;
    logic signed [DW-1:0] r_dy3;
    logic signed [31:0]   r_w3;
    logic signed [31:0]   r_h3;
    // Stage 4: partial products.
    logic  r_v4;
    logic [13:0] r_anchor4;
    logic [7:0]  r_cls4;
    logic [30:0] r_score4;
    logic signed [47:0]   r_px_lo4;
    logic signed [47:0]   r_px_hi4;
    logic signed [47:0]   r_py_lo4;
    logic signed [47:0]   r_py_hi4;
    logic signed [SW-1:0] r_pw4;
    logic signed [SW-1:0] r_ph4;
    // Stage 5: clamped corner and scaled size.
    logic  r_v5;
    logic [13:0] r_anchor5;
    logic [7:0]  r_cls5;
    logic [30:0] r_score5;
    logic [29:0] r_x5;
    logic [29:0] r_y5;
    logic signed [SW-1:0] r_bw5;
    logic signed [SW-1:0] r_bh5;
    // Output register.
    logic        r_ov;
    logic [13:0] r_anchor_o;
    logic [7:0]  r_cls_o;
    logic [30:0] r_score_o;
    logic [29:0] r_x_o;
    logic [29:0] r_y_o;
    logic [29:0] r_w_o;
    logic [29:0] r_h_o;

    logic free_out;
    logic ok5;
    logic go5;
    logic free5;
    logic free4;
    logic free3;
    logic free2;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [12:0]   inv_lo;
    logic signed [12:0]   inv_hi;
    logic signed [24:0]   inv_s;
    logic signed [PW-1:0] x_full;
    logic signed [PW-1:0] y_full;
    logic signed [PW-1:0] x_raw;
    logic signed [PW-1:0] y_raw;
    logic [29:0]          x_cl;
    logic [29:0]          y_cl;
    logic [29:0]          lim_w;
    logic [29:0]          lim_h;
    logic signed [SW-1:0] bw_lim;
    logic signed [SW-1:0] bh_lim;

    assign fw = {i_cfg.frame_width, 16'b0};
    assign fh = {i_cfg.frame_height, 16'b0};

    // Flow control: a stage loads when it is empty or its item moves on.
    always_comb begin
        free_out = !r_ov || o_out.ready;
        go5      = r_v5 && (!ok5 || free_out);
        free5    = !r_v5 || go5;
        free4    = !r_v4 || free5;
        free3    = !r_v3 || free4;
        free2    = !r_v2 || free3;
    end
    assign o_cand_ready = free2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (free2) begin
                r_v2 <= i_cand_valid;
            end
            if (free3) begin
                r_v3 <= r_v2;
            end
            if (free4) begin
                r_v4 <= r_v3;
            end
            if (free5) begin
                r_v5 <= r_v4;
            end
            if (free_out) begin
                r_ov <= go5 && ok5;
            end
        end
    end

    // Centre and size to corner offset, less twice the pad.
    always_comb begin
        dx = (DW'(r_c2.cx) <<< 1) - DW'(r_c2.w)
             - $signed({5'b0, i_cfg.pad_left, 1'b0});
        dy = (DW'(r_c2.cy) <<< 1) - DW'(r_c2.h)
             - $signed({5'b0, i_cfg.pad_top, 1'b0});
    end

    // Inverse scale split in halves to keep each product narrow.
    always_comb begin
        inv_lo = $signed({1'b0, i_cfg.inverse_scale[11:0]});
        inv_hi = $signed({1'b0, i_cfg.inverse_scale[23:12]});
        inv_s  = $signed({1'b0, i_cfg.inverse_scale});
    end

    // Sum of the partial products, floor shift and clamp to the frame.
    always_comb begin
        x_full = PW'(r_px_lo4) + (PW'(r_px_hi4) <<< 12);
        y_full = PW'(r_py_lo4) + (PW'(r_py_hi4) <<< 12);
        x_raw  = x_full >>> (FRAC_BITS + 1);
        y_raw  = y_full >>> (FRAC_BITS + 1);
        if (x_raw < 0) begin
            x_cl = '0;
        end else if (x_raw > $signed(PW'(fw))) begin
            x_cl = fw;
        end else begin
            x_cl = x_raw[29:0];
        end
        if (y_raw < 0) begin
            y_cl = '0;
        end else if (y_raw > $signed(PW'(fh))) begin
            y_cl = fh;
        end else begin
            y_cl = y_raw[29:0];
        end
    end

    // Size limited to the frame edge, then the minimum size check.
    always_comb begin
        lim_w  = fw - r_x5;
        lim_h  = fh - r_y5;
        bw_lim = (r_bw5 > $signed(SW'(lim_w))) ? $signed(SW'(lim_w)) : r_bw5;
        bh_lim = (r_bh5 > $signed(SW'(lim_h))) ? $signed(SW'(lim_h)) : r_bh5;
        ok5    = (bw_lim > ONE) && (bh_lim > ONE);
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (free2 && i_cand_valid) begin
            r_c2 <= i_cand;
        end
        if (free3 && r_v2) begin
            r_anchor3 <= r_c2.anchor;
            r_cls3    <= r_c2.cls;
            r_score3  <= r_c2.score;
            r_dx3     <= dx;
            r_dy3     <= dy;
            r_w3      <= r_c2.w;
            r_h3      <= r_c2.h;
        end
        if (free4 && r_v3) begin
            r_anchor4 <= r_anchor3;
            r_cls4    <= r_cls3;
            r_score4  <= r_score3;
            r_px_lo4  <= 48'(r_dx3) * 48'(inv_lo);
            r_px_hi4  <= 48'(r_dx3) * 48'(inv_hi);
            r_py_lo4  <= 48'(r_dy3) * 48'(inv_lo);
            r_py_hi4  <= 48'(r_dy3) * 48'(inv_hi);
            r_pw4     <= SW'(r_w3) * SW'(inv_s);
            r_ph4     <= SW'(r_h3) * SW'(inv_s);
        end
        if (free5 && r_v4) begin
            r_anchor5 <= r_anchor4;
            r_cls5    <= r_cls4;
            r_score5  <= r_score4;
            r_x5      <= x_cl;
            r_y5      <= y_cl;
            r_bw5     <= r_pw4 >>> FRAC_BITS;
            r_bh5     <= r_ph4 >>> FRAC_BITS;
        end
        if (free_out && go5 && ok5) begin
            r_anchor_o <= r_anchor5;
            r_cls_o    <= r_cls5;
            r_score_o  <= r_score5;
            r_x_o      <= r_x5;
            r_y_o      <= r_y5;
            r_w_o      <= bw_lim[29:0];
            r_h_o      <= bh_lim[29:0];
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.det_anchor = r_anchor_o;
    assign o_out.det_class  = r_cls_o;
    assign o_out.det_score  = r_score_o;
    assign o_out.box_left   = r_x_o;
    assign o_out.box_top    = r_y_o;
    assign o_out.box_width  = r_w_o;
    assign o_out.box_height = r_h_o;

endmodule

### src/detection_head_decode.sv
// Path: a detection passes the read-modify-write stage, the box pipeline and
// its output register; elements that yield nothing leave at once.
// Throughput: one element per cycle unless a kept detection waits, set by one
// read-modify-write of the best score store per element, forwarded back to back.
// Reset: registers return to their reset values and the pipeline empties;
// the box and score stores are not cleared and hold nothing valid until written.
module detection_head_decode #(
    parameter int MAX_ANCHORS = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dhd_in_if.sink      i_in,
    dhd_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [28:0] i_cfg_data
);
    import dhd_pkg::*;

    t_cfg  r_cfg;
    t_cfg  n_cfg;
    logic  cand_valid;
    logic  cand_ready;
    t_cand cand;

    // Configuration register writes.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLASS_COUNT:     n_cfg.class_count     = i_cfg_data[8:0];
                CFG_SCORE_THRESHOLD: n_cfg.score_threshold = i_cfg_data[16:0];
                CFG_PAD_LEFT:        n_cfg.pad_left        = i_cfg_data;
                CFG_PAD_TOP:         n_cfg.pad_top         = i_cfg_data;
                CFG_INVERSE_SCALE:   n_cfg.inverse_scale   = i_cfg_data[23:0];
                CFG_FRAME_WIDTH:     n_cfg.frame_width     = i_cfg_data[13:0];
                CFG_FRAME_HEIGHT:    n_cfg.frame_height    = i_cfg_data[13:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.class_count     <= 9'd80;
            r_cfg.score_threshold <= 17'd16384;
            r_cfg.pad_left        <= '0;
            r_cfg.pad_top         <= '0;
            r_cfg.inverse_scale   <= 24'd65536;
            r_cfg.frame_width     <= 14'd640;
            r_cfg.frame_height    <= 14'd640;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Per-anchor state and running best class.
    dhd_anchor_state #(
        .MAX_ANCHORS (MAX_ANCHORS)
    ) u_anchor_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (r_cfg),
        .o_cand_valid (cand_valid),
        .i_cand_ready (cand_ready),
        .o_cand       (cand)
    );

    // Un-letterbox, clamp and size check.
    dhd_box_math u_box_math (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cand_valid (cand_valid),
        .o_cand_ready (cand_ready),
        .i_cand       (cand),
        .o_out        (o_out)
    );

endmodule

### sim/detection_head_decode_tb.sv
module detection_head_decode_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dhd_pkg::*;

    localparam int     ANCHORS      = 16384;
    localparam int     CYCLE_LIMIT  = 300000;
    localparam int     DRAIN_CYCLES = 16;
    localparam int     LONG_HOLD    = 600;
    localparam int     POOL_SIZE    = 24;
    localparam longint ONE_PIXEL    = 64'sd1 <<< FRAC_BITS;

    // Box channel numbers.
    localparam logic [8:0] CH_CX = 9'd0;
    localparam logic [8:0] CH_CY = 9'd1;
    localparam logic [8:0] CH_W  = 9'd2;
    localparam logic [8:0] CH_H  = 9'd3;

    typedef struct packed {
        logic signed [31:0] value;
        logic [8:0]         channel;
        logic [13:0]        anchor;
    } t_elem;

    typedef struct packed {
        logic [13:0] anchor;
        logic [7:0]  cls;
        logic [30:0] score;
        logic [29:0] box_left;
        logic [29:0] box_top;
        logic [29:0] box_width;
        logic [29:0] box_height;
    } t_det;

    typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PATTERN} t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [28:0] cfg_data;

    dhd_in_if  in_if ();
    dhd_out_if out_if ();

    detection_head_decode #(
        .MAX_ANCHORS(ANCHORS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the register file and of the per-anchor stores.
    t_cfg               cfg;
    logic signed [31:0] box_mem [0:4*ANCHORS-1];
    bit                 box_written [0:4*ANCHORS-1];
    logic signed [31:0] best_score_mem [0:ANCHORS-1];
    logic [8:0]         best_class_mem [0:ANCHORS-1];
    bit                 best_written [0:ANCHORS-1];
    logic [13:0]        anchor_pool [0:POOL_SIZE-1];

    t_elem tensor_q [$];
    t_det  expected_dets [$];

    int pushed_items   = 0;
    int accepted_items = 0;
    int fed_items      = 0;
    int dets_checked   = 0;
    int fail_count     = 0;
    int settings_done  = 0;
    int hold_requests  = 0;
    int cycle_count    = 0;

    // Driver, receiver and monitor state.
    t_elem    next_elem;
    t_det     want;
    int       burst_left;
    int       gap_left;
    int       hold_left;
    int       holds_served;
    int       mode_left;
    t_rx_mode rx_mode;

    function automatic int unsigned classes_in_use();
        return (cfg.class_count < MAX_CLASSES) ? cfg.class_count : MAX_CLASSES;
    endfunction

    // Advance the shadow state by one tensor element; returns 1 when a detection follows.
    function automatic bit decode_element(input t_elem e, output t_det d);
        int unsigned count;
        int unsigned k;
        int unsigned slot;
        longint inv, cx, cy, w, h, fw, fh, x0, y0, bw, bh;
        d = '0;
        slot = {e.anchor, 2'b00};
        if (e.channel < BOX_CHANNELS) begin
            box_mem[slot + e.channel[1:0]] = e.value;
            box_written[slot + e.channel[1:0]] = 1'b1;
            return 1'b0;
        end
        count = classes_in_use();
        k = e.channel - BOX_CHANNELS;
        if (k >= count) begin
            return 1'b0;
        end
        // The first class channel opens a fresh search from score zero.
        if (k == 0) begin
            best_score_mem[e.anchor] = '0;
            best_class_mem[e.anchor] = NO_CLASS;
            best_written[e.anchor] = 1'b1;
        end
        if (e.value > best_score_mem[e.anchor]) begin
            best_score_mem[e.anchor] = e.value;
            best_class_mem[e.anchor] = k[8:0];
        end
        if (k != count - 1) begin
            return 1'b0;
        end

        // Score checks on the last class channel.
        if (best_class_mem[e.anchor] == NO_CLASS || best_score_mem[e.anchor] <= 0) begin
            return 1'b0;
        end
        if (longint'(best_score_mem[e.anchor]) < longint'(cfg.score_threshold)) begin
            return 1'b0;
        end

        // Undo the letterbox, then clamp to the frame.
        inv = longint'(cfg.inverse_scale);
        cx = box_mem[slot];
        cy = box_mem[slot + 1];
        w = box_mem[slot + 2];
        h = box_mem[slot + 3];
        fw = longint'(cfg.frame_width) <<< FRAC_BITS;
        fh = longint'(cfg.frame_height) <<< FRAC_BITS;
        x0 = ((2 * cx - w - 2 * longint'(cfg.pad_left)) * inv) >>> (FRAC_BITS + 1);
        y0 = ((2 * cy - h - 2 * longint'(cfg.pad_top)) * inv) >>> (FRAC_BITS + 1);
        bw = (w * inv) >>> FRAC_BITS;
        bh = (h * inv) >>> FRAC_BITS;
        if (x0 < 0) x0 = 0;
        else if (x0 > fw) x0 = fw;
        if (y0 < 0) y0 = 0;
        else if (y0 > fh) y0 = fh;
        if (bw > fw - x0) bw = fw - x0;
        if (bh > fh - y0) bh = fh - y0;
        if (bw <= ONE_PIXEL || bh <= ONE_PIXEL) begin
            return 1'b0;
        end

        d.anchor = e.anchor;
        d.cls = best_class_mem[e.anchor][7:0];
        d.score = best_score_mem[e.anchor][30:0];
        d.box_left = x0[29:0];
        d.box_top = y0[29:0];
        d.box_width = bw[29:0];
        d.box_height = bh[29:0];
        return 1'b1;
    endfunction

    // Class channels only reach anchors whose box and running best have been written.
    function automatic t_elem make_safe(input t_elem e);
        t_elem s;
        int unsigned slot;
        int i;
        s = e;
        if (s.channel < BOX_CHANNELS) begin
            return s;
        end
        slot = {s.anchor, 2'b00};
        for (i = 0; i < 4; i++) begin
            if (!box_written[slot + i]) begin
                s.channel = 9'(i);
                return s;
            end
        end
        if (!best_written[s.anchor] && !(classes_in_use() > 0 && s.channel == BOX_CHANNELS)) begin
            if (classes_in_use() == 0) begin
                s.channel = 9'($urandom_range(0, 3));
            end else begin
                s.channel = BOX_CHANNELS;
            end
        end
        return s;
    endfunction

    task automatic push_item(input t_elem raw);
        t_elem e;
        t_det d;
        e = make_safe(raw);
        if (e.channel < BOX_CHANNELS || (e.channel - BOX_CHANNELS) < classes_in_use()) begin
            fed_items++;
        end
        if (decode_element(e, d)) begin
            expected_dets = {expected_dets, d};
        end
        tensor_q = {tensor_q, e};
        pushed_items++;
    endtask

    task automatic send(input logic [31:0] value, input int unsigned channel,
                        input int unsigned anchor);
        t_elem e;
        e.value = value;
        e.channel = 9'(channel);
        e.anchor = 14'(anchor);
        push_item(e);
    endtask

    function automatic logic [13:0] pick_anchor();
        if ($urandom_range(0, 9) < 7) begin
            return anchor_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return 14'($urandom_range(0, ANCHORS - 1));
    endfunction

    // Mostly plausible coordinates, some tiny sizes, some raw bit patterns.
    function automatic logic signed [31:0] rand_box(input bit is_size);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            return is_size ? $urandom_range(0, 300 << 16)
                           : $urandom_range(0, 700 << 16) - (30 << 16);
        end else if (pick < 7) begin
            return $urandom_range(0, 2 << 16);
        end
        return $urandom();
    endfunction

    // Scores cluster around the useful range and the threshold.
    function automatic logic signed [31:0] rand_score();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            return $urandom_range(0, 81920) - 16384;
        end else if (pick < 6) begin
            return cfg.score_threshold + $urandom_range(0, 2) - 1;
        end else if (pick < 8) begin
            return $urandom();
        end
        return -$urandom_range(0, 65536);
    endfunction

    // One anchor's box and scores; a broken record is cut short or reordered.
    task automatic gen_record(input logic [13:0] anchor, input bit broken);
        t_elem rec [$];
        t_elem e;
        int i;
        int j;
        e.anchor = anchor;
        for (i = 0; i < 4; i++) begin
            e.channel = 9'(i);
            e.value = rand_box(i >= 2);
            rec = {rec, e};
        end
        for (i = 0; i < classes_in_use(); i++) begin
            e.channel = BOX_CHANNELS + 9'(i);
            e.value = rand_score();
            rec = {rec, e};
        end
        if (broken) begin
            if ($urandom_range(0, 1) == 1) begin
                j = $urandom_range(1, rec.size() - 1);
                while (rec.size() > j) void'(rec.pop_back());
            end else begin
                i = $urandom_range(0, rec.size() - 1);
                j = $urandom_range(0, rec.size() - 1);
                e = rec[i];
                rec[i] = rec[j];
                rec[j] = e;
            end
        end
        foreach (rec[n]) push_item(rec[n]);
    endtask

    // Channel-major order across a few anchors, as the tensor is laid out.
    task automatic gen_frame(input int n_anchors);
        logic [13:0] anchors [$];
        t_elem e;
        int ch;
        int i;
        for (i = 0; i < n_anchors; i++) anchors = {anchors, pick_anchor()};
        for (ch = 0; ch < 4 + classes_in_use(); ch++) begin
            foreach (anchors[n]) begin
                e.anchor = anchors[n];
                e.channel = 9'(ch);
                e.value = (ch < 4) ? rand_box(ch >= 2) : rand_score();
                push_item(e);
            end
        end
    endtask

    task automatic run_random_phase(input int budget);
        int start;
        int pick;
        start = fed_items;
        while (fed_items - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                gen_record(pick_anchor(), 1'b0);
            end else if (pick < 75 && classes_in_use() <= 16) begin
                gen_frame($urandom_range(2, 5));
            end else if (pick < 87) begin
                gen_record(pick_anchor(), 1'b1);
            end else begin
                send($urandom(), $urandom_range(0, 511), pick_anchor());
            end
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data[28:0];
        case (idx)
            CFG_CLASS_COUNT:     cfg.class_count = data[8:0];
            CFG_SCORE_THRESHOLD: cfg.score_threshold = data[16:0];
            CFG_PAD_LEFT:        cfg.pad_left = data[28:0];
            CFG_PAD_TOP:         cfg.pad_top = data[28:0];
            CFG_INVERSE_SCALE:   cfg.inverse_scale = data[23:0];
            CFG_FRAME_WIDTH:     cfg.frame_width = data[13:0];
            CFG_FRAME_HEIGHT:    cfg.frame_height = data[13:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned classes, input int unsigned threshold,
                              input int unsigned pad_x, input int unsigned pad_y,
                              input int unsigned inv_scale, input int unsigned frame_w,
                              input int unsigned frame_h);
        write_reg(CFG_CLASS_COUNT, classes);
        write_reg(CFG_SCORE_THRESHOLD, threshold);
        write_reg(CFG_PAD_LEFT, pad_x);
        write_reg(CFG_PAD_TOP, pad_y);
        write_reg(CFG_INVERSE_SCALE, inv_scale);
        write_reg(CFG_FRAME_WIDTH, frame_w);
        write_reg(CFG_FRAME_HEIGHT, frame_h);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    // Wait until every element is transferred and every detection has arrived.
    task automatic wait_idle();
        while (accepted_items != pushed_items || expected_dets.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.tensor_value <= '0;
            in_if.channel_index <= '0;
            in_if.anchor_index <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                accepted_items <= accepted_items + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0) begin
                    in_if.valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (tensor_q.size() != 0) begin
                    next_elem = tensor_q.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.tensor_value <= next_elem.value;
                    in_if.channel_index <= next_elem.channel;
                    in_if.anchor_index <= next_elem.anchor;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: changing stall patterns, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left <= 0;
            holds_served <= 0;
            mode_left <= 0;
            rx_mode <= RX_ALWAYS;
        end else if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            out_if.ready <= 1'b0;
            hold_left <= LONG_HOLD;
            holds_served <= holds_served + 1;
        end else begin
            if (mode_left == 0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 128);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_ALWAYS: out_if.ready <= 1'b1;
                RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_if.ready <= ($urandom_range(0, 7) == 0);
                default:   out_if.ready <= (mode_left[2:0] != 3'd0);
            endcase
        end
    end

    // Monitor: each detection transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_dets.size() == 0) begin
                $display("%0t: detection with none expected: %s %0d",
                         $time, "expected nothing, actual anchor", out_if.det_anchor);
                fail_count++;
            end else begin
                want = expected_dets.pop_front();
                check_field("det_anchor", want.anchor, out_if.det_anchor);
                check_field("det_class", want.cls, out_if.det_class);
                check_field("det_score", want.score, out_if.det_score);
                check_field("box_left", want.box_left, out_if.box_left);
                check_field("box_top", want.box_top, out_if.box_top);
                check_field("box_width", want.box_width, out_if.box_width);
                check_field("box_height", want.box_height, out_if.box_height);
                dets_checked++;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d detections outstanding", $time, expected_dets.size());
            $display("[detection_head_decode] ERROR");
            $finish;
        end
    end

    initial begin
        cfg_we = 1'b0;
        cfg_index = CFG_CLASS_COUNT;
        cfg_data = '0;

        // Register values after reset.
        cfg.class_count = 9'd80;
        cfg.score_threshold = 17'd16384;
        cfg.pad_left = '0;
        cfg.pad_top = '0;
        cfg.inverse_scale = 24'd65536;
        cfg.frame_width = 14'd640;
        cfg.frame_height = 14'd640;
        anchor_pool[0] = '0;
        anchor_pool[1] = 14'(ANCHORS - 1);
        for (int i = 2; i < POOL_SIZE; i++) anchor_pool[i] = 14'($urandom_range(0, ANCHORS - 1));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners with two classes.
        set_config(2, 16384, 0, 0, 65536, 640, 480);
        // Plain box on anchor 0, the second class wins.
        send(100 << 16, CH_CX, 0);
        send(100 << 16, CH_CY, 0);
        send(50 << 16, CH_W, 0);
        send(40 << 16, CH_H, 0);
        send(32'h0000_8000, BOX_CHANNELS, 0);
        send(32'h0000_C000, BOX_CHANNELS + 1, 0);
        // Extreme box values on the top anchor; a tie keeps class 0, the box fills the frame.
        send(32'h8000_0000, CH_CX, ANCHORS - 1);
        send(32'h0000_0000, CH_CY, ANCHORS - 1);
        send(32'h7FFF_FFFF, CH_W, ANCHORS - 1);
        send(32'h7FFF_FFFF, CH_H, ANCHORS - 1);
        send(32'h7FFF_FFFF, BOX_CHANNELS, ANCHORS - 1);
        send(32'h7FFF_FFFF, BOX_CHANNELS + 1, ANCHORS - 1);
        // No positive score on anchor 1, so no class and no detection.
        send(10 << 16, CH_CX, 1);
        send(10 << 16, CH_CY, 1);
        send(1 << 16, CH_W, 1);
        send(5 << 16, CH_H, 1);
        send(32'h8000_0000, BOX_CHANNELS, 1);
        send(32'h0000_0000, BOX_CHANNELS + 1, 1);
        // A new search on anchor 0 ends exactly on the threshold and is kept.
        send(16384, BOX_CHANNELS, 0);
        send(16383, BOX_CHANNELS + 1, 0);
        // A channel past the last class is dropped.
        send(32'h7FFF_FFFF, 9'h1FF, 0);
        // One step under the threshold on anchor 1.
        send(16383, BOX_CHANNELS, 1);
        send(0, BOX_CHANNELS + 1, 1);
        wait_idle();

        // Random phases over a spread of register settings.
        set_config(4, 16384, 0, 0, 65536, 640, 640);
        run_random_phase(200);
        wait_idle();

        // Single class with padding; the receiver holds off long enough to back up the block.
        set_config(1, 0, 80 << 16, 40 << 16, 2 * 65536, 1280, 720);
        hold_requests <= hold_requests + 1;
        run_random_phase(300);
        wait_idle();

        set_config(0, 16384, 0, 0, 65536, 640, 640);
        run_random_phase(60);
        wait_idle();

        set_config(256, 65536, 0, 0, 65536, 640, 640);
        run_random_phase(260);
        wait_idle();

        // All-ones settings; the class count is limited to the maximum.
        set_config(511, 131071, 29'h1FFF_FFFF, 29'h1FFF_FFFF, 24'hFF_FFFF, 16383, 16383);
        run_random_phase(260);
        wait_idle();

        set_config(3, 1, 0, 0, 0, 640, 640);
        run_random_phase(80);
        wait_idle();

        set_config(2, 100, 0, 0, 65536, 0, 0);
        run_random_phase(60);
        wait_idle();

        set_config(5, 0, 0, 0, 65536, 1, 1);
        run_random_phase(60);
        wait_idle();

        set_config(6, 0, 0, 0, 1, 8192, 8192);
        run_random_phase(60);
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            set_config($urandom_range(1, 8), $urandom_range(0, 65536),
                       $urandom_range(0, 100 << 16), $urandom_range(0, 100 << 16),
                       $urandom_range(16384, 262144), $urandom_range(64, 2048),
                       $urandom_range(64, 2048));
            run_random_phase(120);
            wait_idle();
        end

        $display("Transferred %0d tensor elements under %0d register settings.",
                 accepted_items, settings_done);
        $display("Compared %0d detections over corners, records, frames, noise and a long stall.",
                 dets_checked);
        if (fail_count == 0) begin
            $display("[detection_head_decode] OK");
        end else begin
            $display("[detection_head_decode] ERROR");
        end
        $finish;
    end

endmodule
